### src/i2crm_pkg.sv
package i2crm_pkg;

    localparam int QueueDepth = 2;

    localparam logic [1:0] OpTick  = 2'd0;
    localparam logic [1:0] OpRead  = 2'd1;
    localparam logic [1:0] OpWrite = 2'd2;

    localparam logic [1:0] StatusIdle  = 2'd0;
    localparam logic [1:0] StatusBusy  = 2'd1;
    localparam logic [1:0] StatusDone  = 2'd2;
    localparam logic [1:0] StatusNack  = 2'd3;

    typedef enum logic [1:0] {
        KindTick       = 2'd0,
        KindStartRead  = 2'd1,
        KindStartWrite = 2'd2,
        KindNone       = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] wr_data;
        logic       sda_in;
    } req_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic [1:0] status;
        logic [7:0] read_data;
    } rsp_t;

    typedef struct packed {
        kind_t      kind;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] wr_data;
        logic       sda_in;
    } cmd_t;

endpackage

### src/i2crm_if.sv
interface i2crm_req_if;
    logic             valid;
    logic             ready;
    i2crm_pkg::req_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface i2crm_rsp_if;
    logic             valid;
    logic             ready;
    i2crm_pkg::rsp_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### src/i2crm_front.sv
module i2crm_front (
    i2crm_req_if.sink          req,
    input  logic               queue_full,
    output logic               push,
    output i2crm_pkg::cmd_t    cmd
);

    i2crm_pkg::kind_t kind;

    always_comb
    begin
        case (req.payload.opcode)
            i2crm_pkg::OpTick:  kind = i2crm_pkg::KindTick;
            i2crm_pkg::OpRead:  kind = i2crm_pkg::KindStartRead;
            i2crm_pkg::OpWrite: kind = i2crm_pkg::KindStartWrite;
            default:            kind = i2crm_pkg::KindNone;
        endcase
    end

    assign req.ready = !queue_full;
    assign push      = req.valid && !queue_full;

    assign cmd.kind     = kind;
    assign cmd.dev_addr = req.payload.dev_addr;
    assign cmd.reg_addr = req.payload.reg_addr;
    assign cmd.wr_data  = req.payload.wr_data;
    assign cmd.sda_in   = req.payload.sda_in;

endmodule

### src/i2crm_queue.sv
module i2crm_queue #(
    parameter int DEPTH = i2crm_pkg::QueueDepth
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  i2crm_pkg::cmd_t    push_cmd,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output i2crm_pkg::cmd_t    head_cmd
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    i2crm_pkg::cmd_t mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full       = (count_reg == CntW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### src/i2crm_back.sv
module i2crm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  i2crm_pkg::cmd_t    head_cmd,
    output logic               pop,
    i2crm_rsp_if.source        rsp
);

    localparam logic [8:0] CtrlStart    = 9'h100;
    localparam logic [8:0] CtrlStop     = 9'h101;
    localparam logic [8:0] CtrlRead     = 9'h102;
    localparam logic [8:0] CtrlComplete = 9'h103;
    localparam logic [3:0] BitsPerByte  = 4'd8;

    typedef enum logic [17:0] {
        PhIdle   = 18'h00001,
        PhInit   = 18'h00002,
        PhStart1 = 18'h00004,
        PhStart2 = 18'h00008,
        PhTxS    = 18'h00010,
        PhTxH    = 18'h00020,
        PhTxL    = 18'h00040,
        PhTxAckH = 18'h00080,
        PhTxAckL = 18'h00100,
        PhRxS    = 18'h00200,
        PhRxH    = 18'h00400,
        PhRxL    = 18'h00800,
        PhRxAckH = 18'h01000,
        PhRxAckL = 18'h02000,
        PhStop1  = 18'h04000,
        PhStop2  = 18'h08000,
        PhStop3  = 18'h10000,
        PhStop4  = 18'h20000
    } phase_t;

    // Sequence entries are rebuilt from the saved command fields.
    function automatic logic [8:0] seq_entry(
        input logic       is_read,
        input logic [6:0] dev,
        input logic [7:0] regad,
        input logic [7:0] dat,
        input logic [2:0] idx
    );
        logic [8:0] e;
        begin
            e = CtrlComplete;
            case (idx)
                3'd0: e = {1'b0, dev, 1'b0};
                3'd1: e = {1'b0, regad};
                3'd2: e = is_read ? CtrlStart : {1'b0, dat};
                3'd3: e = is_read ? {1'b0, dev, 1'b1} : CtrlStop;
                3'd4: e = is_read ? CtrlRead : CtrlComplete;
                3'd5: e = is_read ? CtrlStop : CtrlComplete;
                default: e = CtrlComplete;
            endcase
            return e;
        end
    endfunction

    phase_t      phase_reg, phase_next;
    logic [2:0]  step_reg, step_next;
    logic [3:0]  bits_reg, bits_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  rx_reg, rx_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        is_read_reg, is_read_next;
    logic [6:0]  dev_reg, dev_next;
    logic [7:0]  regad_reg, regad_next;
    logic [7:0]  dat_reg, dat_next;
    logic        out_valid_reg, out_valid_next;
    i2crm_pkg::rsp_t out_reg, out_next;

    logic        fire;
    logic        do_advance;
    logic [1:0]  status;
    logic [2:0]  step_inc;
    logic [2:0]  adv_step;
    logic [8:0]  adv_entry;
    logic [8:0]  cur_entry;
    logic        nak_next;
    logic [3:0]  bits_dec;
    logic        busy;

    assign fire     = head_valid && (!out_valid_reg || rsp.ready);
    assign pop      = fire;
    assign busy     = (phase_reg != PhIdle);
    assign step_inc = step_reg + 3'd1;
    assign bits_dec = bits_reg - 4'd1;
    assign cur_entry = seq_entry(is_read_reg, dev_reg, regad_reg, dat_reg, step_reg);
    assign adv_entry = seq_entry(is_read_reg, dev_reg, regad_reg, dat_reg, step_inc);
    assign adv_step  = step_inc + 3'd1;
    assign nak_next  = (adv_entry != CtrlRead);

    always_comb
    begin
        phase_next   = phase_reg;
        step_next    = step_reg;
        bits_next    = bits_reg;
        shift_next   = shift_reg;
        rx_next      = rx_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        is_read_next = is_read_reg;
        dev_next     = dev_reg;
        regad_next   = regad_reg;
        dat_next     = dat_reg;
        do_advance   = 1'b0;
        status       = busy ? i2crm_pkg::StatusBusy : i2crm_pkg::StatusIdle;

        case (head_cmd.kind)
            i2crm_pkg::KindTick:
            begin
                case (phase_reg)
                    PhInit:
                    begin
                        step_next  = 3'd0;
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                        phase_next = PhStart1;
                    end
                    PhStart1:
                    begin
                        scl_next   = 1'b1;
                        sda_next   = 1'b0;
                        phase_next = PhStart2;
                    end
                    PhStart2:
                    begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        bits_next  = BitsPerByte;
                        shift_next = cur_entry[7:0];
                        phase_next = PhTxS;
                    end
                    PhTxS:
                    begin
                        scl_next   = 1'b0;
                        sda_next   = shift_reg[7];
                        phase_next = PhTxH;
                    end
                    PhTxH:
                    begin
                        scl_next   = 1'b1;
                        sda_next   = shift_reg[7];
                        phase_next = PhTxL;
                    end
                    PhTxL:
                    begin
                        scl_next   = 1'b0;
                        shift_next = {shift_reg[6:0], 1'b0};
                        bits_next  = bits_dec;
                        if (bits_dec != 4'd0)
                        begin
                            sda_next   = shift_reg[7];
                            phase_next = PhTxS;
                        end
                        else
                        begin
                            sda_next   = 1'b1;
                            phase_next = PhTxAckH;
                        end
                    end
                    PhTxAckH:
                    begin
                        if (head_cmd.sda_in)
                        begin
                            phase_next = PhIdle;
                            status     = i2crm_pkg::StatusNack;
                        end
                        else
                        begin
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                            phase_next = PhTxAckL;
                        end
                    end
                    PhTxAckL:
                    begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                        do_advance = 1'b1;
                    end
                    PhRxS:
                    begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                        phase_next = PhRxH;
                    end
                    PhRxH:
                    begin
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                        phase_next = PhRxL;
                    end
                    PhRxL:
                    begin
                        rx_next   = {rx_reg[6:0], head_cmd.sda_in};
                        bits_next = bits_dec;
                        scl_next  = 1'b0;
                        if (bits_dec != 4'd0)
                        begin
                            sda_next   = 1'b1;
                            phase_next = PhRxS;
                        end
                        else
                        begin
                            sda_next   = nak_next;
                            phase_next = PhRxAckH;
                        end
                    end
                    PhRxAckH:
                    begin
                        scl_next   = 1'b1;
                        sda_next   = nak_next;
                        phase_next = PhRxAckL;
                    end
                    PhRxAckL:
                    begin
                        scl_next   = 1'b0;
                        sda_next   = nak_next;
                        do_advance = 1'b1;
                    end
                    PhStop1:
                    begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        phase_next = PhStop2;
                    end
                    PhStop2:
                    begin
                        scl_next   = 1'b1;
                        sda_next   = 1'b0;
                        phase_next = PhStop3;
                    end
                    PhStop3:
                    begin
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                        phase_next = PhStop4;
                    end
                    PhStop4:
                    begin
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                        phase_next = PhIdle;
                        status     = i2crm_pkg::StatusDone;
                    end
                    default:
                    begin
                        phase_next = PhIdle;
                        status     = i2crm_pkg::StatusIdle;
                    end
                endcase
            end
            i2crm_pkg::KindStartRead, i2crm_pkg::KindStartWrite:
            begin
                if (!busy)
                begin
                    is_read_next = (head_cmd.kind == i2crm_pkg::KindStartRead);
                    dev_next     = head_cmd.dev_addr;
                    regad_next   = head_cmd.reg_addr;
                    dat_next     = head_cmd.wr_data;
                    phase_next   = PhInit;
                end
                status = i2crm_pkg::StatusBusy;
            end
            default:
            begin
                status = busy ? i2crm_pkg::StatusBusy : i2crm_pkg::StatusIdle;
            end
        endcase

        if (do_advance)
        begin
            bits_next = BitsPerByte;
            step_next = step_inc;
            status    = i2crm_pkg::StatusBusy;
            if (adv_entry == CtrlStart)
            begin
                phase_next = PhStart1;
                step_next  = adv_step;
            end
            else if (adv_entry == CtrlStop)
            begin
                phase_next = PhStop1;
                step_next  = adv_step;
            end
            else if (adv_entry == CtrlRead)
            begin
                rx_next    = 8'd0;
                phase_next = PhRxS;
            end
            else if (adv_entry == CtrlComplete)
            begin
                phase_next = PhIdle;
                status     = i2crm_pkg::StatusDone;
            end
            else
            begin
                shift_next = adv_entry[7:0];
                phase_next = PhTxS;
            end
        end
    end

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        out_next          = out_reg;
        if (fire)
        begin
            out_valid_next     = 1'b1;
            out_next.scl       = scl_next;
            out_next.sda_out   = sda_next;
            out_next.status    = status;
            out_next.read_data = rx_next;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PhIdle;
            step_reg      <= 3'd0;
            bits_reg      <= 4'd0;
            shift_reg     <= 8'd0;
            rx_reg        <= 8'd0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            is_read_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                phase_reg   <= phase_next;
                step_reg    <= step_next;
                bits_reg    <= bits_next;
                shift_reg   <= shift_next;
                rx_reg      <= rx_next;
                scl_reg     <= scl_next;
                sda_reg     <= sda_next;
                is_read_reg <= is_read_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (fire)
        begin
            dev_reg   <= dev_next;
            regad_reg <= regad_next;
            dat_reg   <= dat_next;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

endmodule

### src/i2c_register_master.sv
// Channel | Dir | Payload                                   | Beat
// req     | in  | opcode, dev_addr, reg_addr, wr_data, sda_in | one command or line tick
// rsp     | out | scl, sda_out, status, read_data           | one result per req beat
//
// The block takes one req beat per cycle while the queue is not full and returns one rsp beat per req beat.
// A beat enters the command queue at acceptance; once it reaches the queue head and rsp
// is not stalled, its result is registered in the output register.
// A stalled rsp holds the output register; req keeps flowing until the queue fills.
// Reset leaves the bus released, the sequencer idle and the receive register at zero.
module i2c_register_master #(
    parameter int QUEUE_DEPTH = i2crm_pkg::QueueDepth
) (
    input  logic         clk,
    input  logic         rst_n,
    i2crm_req_if.sink    req,
    i2crm_rsp_if.source  rsp
);

    logic              push;
    logic              queue_full;
    logic              pop;
    logic              head_valid;
    i2crm_pkg::cmd_t   push_cmd;
    i2crm_pkg::cmd_t   head_cmd;

    i2crm_front u_front (
        .req        (req),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    i2crm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    i2crm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule
